@@ design/vsp_pkg.sv @@
// Shared types, constants and field layout for the varispeed sample player.
package vsp_pkg;

  // Default configuration of storage and fixed-point format
  localparam int unsigned MEMORY_DEPTH_DEF  = 65536;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int OP_W      = 2;
  localparam int ADDR_IN_W = 16;
  localparam int BYTE_W    = 8;
  localparam int SEEK_W    = 17;
  localparam int SAMPLE_W  = 16;
  localparam int SPEED_W   = 24;
  localparam int GAIN_W    = 16;
  localparam int LEN_W     = 17;
  localparam int POS_W     = 32;

  // Input tdata layout, lowest field first
  localparam int IN_DATA_W   = 48;
  localparam int IN_ADDR_LSB = 0;
  localparam int IN_BYTE_LSB = IN_ADDR_LSB + ADDR_IN_W;
  localparam int IN_SEEK_LSB = IN_BYTE_LSB + BYTE_W;
  localparam int IN_FLAG_BIT = IN_SEEK_LSB + SEEK_W;

  // Arithmetic constants
  localparam int SAMPLE_BIAS     = 128;
  localparam int GAIN_SHIFT      = 12;
  localparam int SPEED_FLOOR_DIV = 1000;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_RENDER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SEEK   = 2'd2,
    OP_PLAY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SPEED  = 2'd0,
    REG_GAIN   = 2'd1,
    REG_MUTE   = 2'd2,
    REG_LENGTH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_MUL,
    ST_ADD,
    ST_SCL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [GAIN_W-1:0]  gain;
    logic               mute;
    logic [LEN_W-1:0]   length;
  } cfg_t;

  typedef struct packed {
    logic ld_first;
    logic ld_second;
    logic rd_ok;
  } interp_ctl_t;

  localparam cfg_t CFG_RESET = '{
    speed:  SPEED_W'(65536),
    gain:   GAIN_W'(4096),
    mute:   1'b0,
    length: LEN_W'(0)
  };

endpackage

@@ design/vsp_regs.sv @@
// Configuration register file behind the APB-style port.
module vsp_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [vsp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output vsp_pkg::cfg_t                   cfg
);
  import vsp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Decode the write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SPEED:  cfg_nxt.speed  = cfg_pwdata[SPEED_W-1:0];
        REG_GAIN:   cfg_nxt.gain   = cfg_pwdata[GAIN_W-1:0];
        REG_MUTE:   cfg_nxt.mute   = cfg_pwdata[0];
        REG_LENGTH: cfg_nxt.length = cfg_pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_SPEED:  cfg_prdata = CFG_DATA_W'(cfg_r.speed);
      REG_GAIN:   cfg_prdata = CFG_DATA_W'(cfg_r.gain);
      REG_MUTE:   cfg_prdata = CFG_DATA_W'(cfg_r.mute);
      REG_LENGTH: cfg_prdata = CFG_DATA_W'(cfg_r.length);
    endcase
  end

endmodule

@@ design/vsp_mem.sv @@
// Sample byte memory: one write port, one registered read port.
module vsp_mem #(
  parameter  int unsigned DEPTH  = vsp_pkg::MEMORY_DEPTH_DEF,
  localparam int          ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [vsp_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [vsp_pkg::BYTE_W-1:0] rd_data
);
  import vsp_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  // Write and read the array; read data is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

@@ design/vsp_interp.sv @@
// Interpolation and gain pipeline: two neighbor samples in, one saturated sample out.
module vsp_interp #(
  parameter int unsigned FRAC_W = vsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  vsp_pkg::interp_ctl_t                ctl,
  input  logic [vsp_pkg::BYTE_W-1:0]          rd_byte,
  input  logic [FRAC_W-1:0]                   frac,
  input  logic [vsp_pkg::GAIN_W-1:0]          gain,
  output logic signed [vsp_pkg::SAMPLE_W-1:0] sample
);
  import vsp_pkg::*;

  localparam int D_W    = SAMPLE_W + 1;
  localparam int PROD_W = D_W + FRAC_W + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int V_W    = SAMPLE_W + 1;
  localparam int Y_W    = V_W + GAIN_W + 1;
  localparam int YS_W   = Y_W - GAIN_SHIFT;
  localparam logic signed [YS_W-1:0] SAT_MAX = YS_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [YS_W-1:0] SAT_MIN = YS_W'(-(1 <<< (SAMPLE_W - 1)));

  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [SAMPLE_W-1:0] s1_r;
  logic signed [SAMPLE_W-1:0] s2_r;
  logic signed [D_W-1:0]      diff;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    num_adj;
  logic signed [V_W-1:0]      v_nxt;
  logic signed [V_W-1:0]      v_r;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [Y_W-1:0]      y_nxt;
  logic signed [Y_W-1:0]      y_r;
  logic signed [Y_W-1:0]      y_adj;
  logic signed [YS_W-1:0]     y_sh;

  // Flip the top bit to remove the bias, then move into the high byte
  assign rd_sample = ctl.rd_ok
                   ? $signed({rd_byte ^ BYTE_W'(SAMPLE_BIAS), {(SAMPLE_W-BYTE_W){1'b0}}})
                   : '0;

  // Stage 1: slope times fraction
  assign diff     = D_W'(s2_r) - D_W'(s1_r);
  assign frac_s   = $signed({1'b0, frac});
  assign prod_nxt = PROD_W'(diff) * PROD_W'(frac_s);

  // Stage 2: add the base sample and truncate toward zero
  assign num     = (NUM_W'(s1_r) <<< FRAC_W) + NUM_W'(prod_r);
  assign num_adj = num + (num[NUM_W-1] ? NUM_W'({FRAC_W{1'b1}}) : '0);
  assign v_nxt   = V_W'(num_adj >>> FRAC_W);

  // Stage 3: apply gain
  assign gain_s = $signed({1'b0, gain});
  assign y_nxt  = Y_W'(v_r) * Y_W'(gain_s);

  // Output: drop the gain fraction toward zero, then saturate
  assign y_adj = y_r + (y_r[Y_W-1] ? Y_W'({GAIN_SHIFT{1'b1}}) : '0);
  assign y_sh  = YS_W'(y_adj >>> GAIN_SHIFT);

  always_comb begin
    if (y_sh > SAT_MAX) begin
      sample = SAT_MAX[SAMPLE_W-1:0];
    end else if (y_sh < SAT_MIN) begin
      sample = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample = y_sh[SAMPLE_W-1:0];
    end
  end

  // Capture the neighbors and advance the stages
  always_ff @(posedge clk) begin
    if (ctl.ld_first) begin
      s1_r <= rd_sample;
    end
    if (ctl.ld_second) begin
      s2_r <= rd_sample;
    end
    prod_r <= prod_nxt;
    v_r    <= v_nxt;
    y_r    <= y_nxt;
  end

endmodule

@@ design/varispeed_sample_player_top.sv @@
// Top level of the varispeed sample player: sequencer, position state and channels.
//
// Items arrive on the in_ channel; in_tuser carries the opcode (render, write byte,
// seek, set play flag) and in_tdata the operands. Each render item yields one signed
// 16-bit sample on the out_ channel; other items yield nothing. Registers (speed,
// gain, mute, buffer length) are written through the cfg_ APB-style port; the user must
// write them only while idle, the block itself does not enforce it. Write, seek and
// play items complete on acceptance. A playing render does two reads through the sample
// memory's single read port, then slope multiply, add, gain multiply and saturation, one
// register stage each. A render while stopped or with zero length skips to the final
// step and gives 0. A new item is taken in the cycle its predecessor's result appears,
// so a render ends before the next item is accepted. The output register holds a result
// while out_tready is low; further non-render items are still accepted, and the next
// render waits in its final step until the register is free. Reset stops playback,
// clears position and fraction and loads register defaults; sample memory is not cleared.
module varispeed_sample_player_top #(
  parameter int unsigned MEMORY_DEPTH  = vsp_pkg::MEMORY_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = vsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] sample_address, [23:16] sample_byte, [40:24] seek_position, [41] play_flag
  input  logic [vsp_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  logic [vsp_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] audio_sample
  output logic [vsp_pkg::SAMPLE_W-1:0]    out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [vsp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import vsp_pkg::*;

  localparam int          ADDR_W      = $clog2(MEMORY_DEPTH);
  localparam int          CHK_W       = POS_W + 1;
  localparam int          ACC_W       = SPEED_W + 1;
  localparam int unsigned SPEED_FLOOR =
    ((1 << FRACTION_BITS) + SPEED_FLOOR_DIV - 1) / SPEED_FLOOR_DIV;

  cfg_t        cfg;
  interp_ctl_t ctl;
  state_t      state_r, state_nxt;

  logic [POS_W-1:0]         position_r, position_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic                     playing_r, playing_nxt;
  logic                     zero_r, zero_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]      out_data_r, out_data_nxt;

  op_t                 op;
  logic [ADDR_IN_W-1:0] in_addr;
  logic [BYTE_W-1:0]   in_byte;
  logic [SEEK_W-1:0]   in_seek;
  logic                in_flag;
  logic                accept;
  logic                active;

  logic [CHK_W-1:0]    p1_ext, p2_ext, len_ext, depth_ext;
  logic                ok1, ok2;
  logic                mem_we;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   rd_byte;
  logic [GAIN_W-1:0]   gain_eff;
  logic [SPEED_W-1:0]  speed_eff;
  logic [ACC_W-1:0]    acc;
  logic [SEEK_W-1:0]   seek_clamped;
  logic signed [SAMPLE_W-1:0] sample;

  // Unpack the input transaction
  assign op      = op_t'(in_tuser);
  assign in_addr = in_tdata[IN_ADDR_LSB +: ADDR_IN_W];
  assign in_byte = in_tdata[IN_BYTE_LSB +: BYTE_W];
  assign in_seek = in_tdata[IN_SEEK_LSB +: SEEK_W];
  assign in_flag = in_tdata[IN_FLAG_BIT];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign active = (cfg.length != '0) & playing_r;

  // Neighbor positions and their range checks
  assign p1_ext    = CHK_W'(position_r);
  assign p2_ext    = p1_ext + CHK_W'(1);
  assign len_ext   = CHK_W'(cfg.length);
  assign depth_ext = CHK_W'(MEMORY_DEPTH);
  assign ok1       = (p1_ext < len_ext) && (p1_ext < depth_ext);
  assign ok2       = (p2_ext < len_ext) && (p2_ext < depth_ext);

  // First neighbor is addressed while idle, second during the first read
  assign rd_addr = (state_r == ST_RD1) ? p2_ext[ADDR_W-1:0] : position_r[ADDR_W-1:0];
  assign mem_we  = accept && (op == OP_WRITE) && (CHK_W'(in_addr) < depth_ext);

  assign gain_eff  = cfg.mute ? '0 : cfg.gain;
  assign speed_eff = (cfg.speed < SPEED_W'(SPEED_FLOOR)) ? SPEED_W'(SPEED_FLOOR) : cfg.speed;
  assign acc       = ACC_W'(frac_r) + ACC_W'(speed_eff);

  assign seek_clamped = ((cfg.length != '0) && (in_seek > cfg.length)) ? cfg.length : in_seek;

  vsp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  vsp_mem #(
    .DEPTH (MEMORY_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (ADDR_W'(in_addr)),
    .wr_data (in_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_byte)
  );

  vsp_interp #(
    .FRAC_W (FRACTION_BITS)
  ) u_interp (
    .clk     (clk),
    .ctl     (ctl),
    .rd_byte (rd_byte),
    .frac    (frac_r),
    .gain    (gain_eff),
    .sample  (sample)
  );

  // Sequence items and update the playback state
  always_comb begin
    state_nxt     = state_r;
    position_nxt  = position_r;
    frac_nxt      = frac_r;
    playing_nxt   = playing_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '0;

    // Drop the result once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_RENDER: begin
              zero_nxt  = !active;
              state_nxt = active ? ST_RD1 : ST_OUT;
            end
            OP_WRITE: begin
            end
            OP_SEEK: begin
              position_nxt = POS_W'(seek_clamped);
              frac_nxt     = '0;
            end
            OP_PLAY: begin
              playing_nxt = in_flag;
            end
          endcase
        end
      end
      ST_RD1: begin
        ctl.ld_first = 1'b1;
        ctl.rd_ok    = ok1;
        state_nxt    = ST_RD2;
      end
      ST_RD2: begin
        ctl.ld_second = 1'b1;
        ctl.rd_ok     = ok2;
        state_nxt     = ST_MUL;
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_SCL;
      ST_SCL: state_nxt = ST_OUT;
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = zero_r ? '0 : sample;
          if (!zero_r) begin
            position_nxt = position_r + POS_W'(acc[ACC_W-1:FRACTION_BITS]);
            frac_nxt     = acc[FRACTION_BITS-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      position_r  <= '0;
      frac_r      <= '0;
      playing_r   <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      frac_r      <= frac_nxt;
      playing_r   <= playing_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
